// ===== design/gpa_pkg.sv =====
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared constants, types and the per-bit step function of the GF(2)
// polynomial arithmetic pipeline.
// ----------------------------------------------------------------------------
package gpa_pkg;

  // operand bits in use; port widths stay fixed at IN_W
  localparam int OPERAND_BITS    = 32;
  localparam int IN_W            = 32;
  localparam int RESULT_W        = 63;
  localparam int PROD_W          = 2 * OPERAND_BITS - 1;
  localparam int IDX_W           = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
  localparam int CNT_W           = $clog2(OPERAND_BITS + 1);

  // bit steps done by one pipeline stage
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STEP_STAGES = (OPERAND_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // leading-one search over the divisor, split in byte groups
  localparam int GRP_W           = 8;
  localparam int GRP_IDX_W       = $clog2(GRP_W);
  localparam int NUM_GRP         = (OPERAND_BITS + GRP_W - 1) / GRP_W;
  localparam int PAD_W           = NUM_GRP * GRP_W;

  // accept edge to the edge that takes the result
  localparam int LATENCY         = NUM_STEP_STAGES + 4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_QUO = 2'd2,
    OP_REM = 2'd3
  } opcode_t;

  // working word carried down the step pipeline
  typedef struct packed {
    opcode_t                 op;
    logic                    zero;   // divisor is zero
    logic [CNT_W-1:0]        cnt;    // division steps still to do
    logic [PROD_W-1:0]       acc;    // product, sum, or remainder in low bits
    logic [PROD_W-1:0]       mcand;  // multiplicand, moves up one bit per step
    logic [OPERAND_BITS-1:0] dvsr;   // multiplier or aligned divisor, moves down
    logic [OPERAND_BITS-1:0] pos;    // one-hot remainder bit under test
    logic [OPERAND_BITS-1:0] quo;    // quotient, shifted in msb first
  } gpa_word_t;

  // one bit step of multiply or long division
  function automatic gpa_word_t gpa_step(input gpa_word_t w_in);
    gpa_word_t w;
    logic      t;
    w = w_in;
    t = 1'b0;
    unique case (w.op)
      OP_MUL: begin
        if (w.dvsr[0]) begin
          w.acc = w.acc ^ w.mcand;
        end
        w.mcand = w.mcand << 1;
        w.dvsr  = w.dvsr >> 1;
      end
      OP_QUO, OP_REM: begin
        if (w.cnt != '0) begin
          t = |(w.acc[OPERAND_BITS-1:0] & w.pos);
          if (t) begin
            w.acc[OPERAND_BITS-1:0] = w.acc[OPERAND_BITS-1:0] ^ w.dvsr;
          end
          w.quo  = {w.quo[OPERAND_BITS-2:0], t};
          w.dvsr = w.dvsr >> 1;
          w.pos  = w.pos >> 1;
          w.cnt  = w.cnt - CNT_W'(1);
        end
      end
      default: begin
        // add is finished before the step stages
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/gf2_polynomial_alu_core.sv =====
// ----------------------------------------------------------------------------
// gf2_polynomial_alu_core
// GF(2) polynomial add, carry-less multiply, quotient and remainder.
// ----------------------------------------------------------------------------
// The unit takes one word in every clock cycle (busy is always low) and
// passes each through the pipeline: one stage registers the operands and
// searches the divisor's byte groups for its top bit, one picks the
// divisor degree, one aligns the divisor, then NUM_STEP_STAGES stages each
// do STEPS_PER_STAGE bit steps of the multiply or long division, and the
// output register drives out_valid for one cycle. Results leave in input
// order and cannot be held off. A zero divisor on quotient or remainder
// returns zero with out_divide_by_zero set.
module gf2_polynomial_alu_core
  import gpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [IN_W-1:0]     in_operand_a,
  input  logic [IN_W-1:0]     in_operand_b,
  output logic                out_valid,
  output logic [RESULT_W-1:0] out_result,
  output logic                out_divide_by_zero
);

  // fully pipelined, never stalls
  assign busy = 1'b0;

  logic                     accept;
  logic [PAD_W-1:0]         in_b_pad;
  logic [NUM_GRP-1:0]       grp_nz;
  logic [GRP_IDX_W-1:0]     grp_idx [NUM_GRP];

  logic                     p0_valid_r;
  opcode_t                  p0_op_r;
  logic [OPERAND_BITS-1:0]  p0_a_r;
  logic [OPERAND_BITS-1:0]  p0_b_r;
  logic [NUM_GRP-1:0]       p0_nz_r;
  logic [GRP_IDX_W-1:0]     p0_idx_r [NUM_GRP];

  logic [IDX_W-1:0]         sh_nxt;
  logic                     p1_valid_r;
  opcode_t                  p1_op_r;
  logic [OPERAND_BITS-1:0]  p1_a_r;
  logic [OPERAND_BITS-1:0]  p1_b_r;
  logic [IDX_W-1:0]         p1_sh_r;

  gpa_word_t                init_nxt;
  logic                     s_valid [NUM_STEP_STAGES+1];
  gpa_word_t                s_word  [NUM_STEP_STAGES+1];
  logic                     s0_valid_r;
  gpa_word_t                s0_word_r;

  gpa_word_t                last_w;
  logic [RESULT_W-1:0]      result_nxt;
  logic                     dbz_nxt;
  logic                     out_valid_r;
  logic [RESULT_W-1:0]      out_result_r;
  logic                     out_dbz_r;

  assign accept   = start & ~busy;
  assign in_b_pad = PAD_W'(in_operand_b[OPERAND_BITS-1:0]);

  // top set bit inside each byte group of the divisor
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_nz[g]  = |in_b_pad[g*GRP_W +: GRP_W];
      grp_idx[g] = '0;
      for (int j = 0; j < GRP_W; j++) begin
        if (in_b_pad[g*GRP_W + j]) begin
          grp_idx[g] = GRP_IDX_W'(j);
        end
      end
    end
  end

  // stage 0: operand register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else begin
      p0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p0_op_r  <= opcode_t'(in_opcode);
    p0_a_r   <= in_operand_a[OPERAND_BITS-1:0];
    p0_b_r   <= in_operand_b[OPERAND_BITS-1:0];
    p0_nz_r  <= grp_nz;
    p0_idx_r <= grp_idx;
  end

  // divisor degree from the highest non-empty group, turned into align shift
  always_comb begin
    int db;
    db = 0;
    for (int g = 0; g < NUM_GRP; g++) begin
      if (p0_nz_r[g]) begin
        db = g * GRP_W + int'(p0_idx_r[g]);
      end
    end
    sh_nxt = IDX_W'(OPERAND_BITS - 1 - db);
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_op_r <= p0_op_r;
    p1_a_r  <= p0_a_r;
    p1_b_r  <= p0_b_r;
    p1_sh_r <= sh_nxt;
  end

  // set up the working word: align divisor so its top bit is the msb
  always_comb begin
    init_nxt       = '0;
    init_nxt.op    = p1_op_r;
    init_nxt.zero  = (p1_b_r == '0);
    init_nxt.cnt   = CNT_W'(p1_sh_r) + CNT_W'(1);
    init_nxt.mcand = PROD_W'(p1_a_r);
    init_nxt.pos   = {1'b1, (OPERAND_BITS-1)'(0)};
    init_nxt.quo   = '0;
    unique case (p1_op_r)
      OP_ADD: begin
        init_nxt.acc  = PROD_W'(p1_a_r ^ p1_b_r);
        init_nxt.dvsr = p1_b_r;
      end
      OP_MUL: begin
        init_nxt.acc  = '0;
        init_nxt.dvsr = p1_b_r;
      end
      OP_QUO, OP_REM: begin
        init_nxt.acc  = PROD_W'(p1_a_r);
        init_nxt.dvsr = p1_b_r << p1_sh_r;
      end
      default: begin
        init_nxt.acc  = '0;
        init_nxt.dvsr = p1_b_r;
      end
    endcase
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_word_r <= init_nxt;
  end

  assign s_valid[0] = s0_valid_r;
  assign s_word[0]  = s0_word_r;

  // bit step stages
  for (genvar s = 0; s < NUM_STEP_STAGES; s++) begin : g_step
    gpa_step_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (s_valid[s]),
      .word_i  (s_word[s]),
      .valid_o (s_valid[s+1]),
      .word_o  (s_word[s+1])
    );
  end

  // pick the result word
  always_comb begin
    last_w  = s_word[NUM_STEP_STAGES];
    dbz_nxt = 1'b0;
    unique case (last_w.op)
      OP_ADD, OP_MUL: begin
        result_nxt = RESULT_W'(last_w.acc);
      end
      OP_QUO: begin
        dbz_nxt    = last_w.zero;
        result_nxt = last_w.zero ? '0 : RESULT_W'(last_w.quo);
      end
      OP_REM: begin
        dbz_nxt    = last_w.zero;
        result_nxt = last_w.zero ? '0 : RESULT_W'(last_w.acc[OPERAND_BITS-1:0]);
      end
      default: begin
        result_nxt = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_valid[NUM_STEP_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= result_nxt;
    out_dbz_r    <= dbz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result         = out_result_r;
  assign out_divide_by_zero = out_dbz_r;

endmodule

// ===== design/gpa_step_stage.sv =====
// ----------------------------------------------------------------------------
// gpa_step_stage
// One register stage of the step pipeline: STEPS_PER_STAGE multiply or
// division bit steps followed by the stage register.
// ----------------------------------------------------------------------------
module gpa_step_stage
  import gpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  input  gpa_word_t word_i,
  output logic      valid_o,
  output gpa_word_t word_o
);

  logic      valid_r;
  gpa_word_t word_r;
  gpa_word_t word_nxt;

  // chain of bit steps
  always_comb begin
    word_nxt = word_i;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      word_nxt = gpa_step(word_nxt);
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

// ===== design/gpa_checker.sv =====
// ----------------------------------------------------------------------------
// gpa_checker
// Port-level checks of the polynomial unit: fixed latency, error flag
// source and the add path.
// ----------------------------------------------------------------------------
module gpa_checker
  import gpa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [1:0]          in_opcode,
  input logic [IN_W-1:0]     in_operand_a,
  input logic [IN_W-1:0]     in_operand_b,
  input logic                out_valid,
  input logic [RESULT_W-1:0] out_result,
  input logic                out_divide_by_zero
);

  logic acc_word;
  assign acc_word = start & ~busy & rst_n;

  // every accepted word comes back after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    acc_word |-> ##LATENCY out_valid)
    else $error("accepted word did not return after fixed latency");

  // no result without a word accepted at the matching edge
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_word, LATENCY))
    else $error("result word without a matching input word");

  // error flag only for a division with a zero divisor, and then zero result
  a_dbz_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      ($past(in_opcode[1], LATENCY) &&
       ($past(in_operand_b[OPERAND_BITS-1:0], LATENCY) == '0) &&
       (out_result == '0)))
    else $error("divide by zero flag without zero divisor or nonzero result");

  // add returns the xor of the operands
  a_add_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_opcode, LATENCY) == OP_ADD)) |->
      ((out_result == RESULT_W'($past(in_operand_a[OPERAND_BITS-1:0] ^
                                      in_operand_b[OPERAND_BITS-1:0], LATENCY)))
       && !out_divide_by_zero))
    else $error("add result mismatch");

endmodule

bind gf2_polynomial_alu_core gpa_checker u_gpa_checker (.*);

// ===== verif/gf2_polynomial_alu_core_tb.sv =====
// ----------------------------------------------------------------------------
// gf2_polynomial_alu_core_tb
// Self-checking bench for the GF(2) polynomial unit: a short table of corner
// words, most with typed answers, then random add, multiply, quotient and
// remainder words at several sender idle rates, others by bit-level predictor.
// ----------------------------------------------------------------------------
module gf2_polynomial_alu_core_tb;
  import gpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IN_W-1:0] OPER_MASK    = {IN_W{1'b1}} >> (IN_W - OPERAND_BITS);
  localparam int              STALL_LIMIT  = 2000;
  localparam int              NUM_PROBES   = 24;
  localparam int              RANDOM_WORDS = 1500;

  // one predicted answer of the unit
  typedef struct packed {
    logic [RESULT_W-1:0] result;
    logic                dbz;
  } gf2_answer_t;

  // corner word, with a hand-written answer where it is obvious
  typedef struct packed {
    opcode_t             op;
    logic [IN_W-1:0]     a;
    logic [IN_W-1:0]     b;
    logic                typed;
    logic [RESULT_W-1:0] result;
    logic                dbz;
  } probe_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_opcode;
  logic [IN_W-1:0]     in_operand_a;
  logic [IN_W-1:0]     in_operand_b;
  logic                out_valid;
  logic [RESULT_W-1:0] out_result;
  logic                out_divide_by_zero;

  gf2_answer_t         expected_answers[$];
  int unsigned         error_count;
  int unsigned         stall_cycles;
  int unsigned         checked_count;
  int unsigned         op_count[4];
  int unsigned         zero_divisor_count;

  probe_row_t probe_rows [NUM_PROBES] = '{
    // add extremes
    '{OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, 63'h0, 1'b0},
    '{OP_ADD, 32'hffff_ffff, 32'h0000_0000, 1'b1, 63'hffff_ffff, 1'b0},
    '{OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 63'h0, 1'b0},
    '{OP_ADD, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 1'b1, 63'hffff_ffff, 1'b0},
    '{OP_ADD, 32'h0000_0000, 32'h8000_0000, 1'b1, 63'h8000_0000, 1'b0},
    // multiply: zero, constant term, top bits, full width
    '{OP_MUL, 32'h0000_0000, 32'hffff_ffff, 1'b1, 63'h0, 1'b0},
    '{OP_MUL, 32'hffff_ffff, 32'h0000_0001, 1'b1, 63'hffff_ffff, 1'b0},
    '{OP_MUL, 32'h0000_0001, 32'h8000_0000, 1'b1, 63'h8000_0000, 1'b0},
    '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1, 63'h4000_0000_0000_0000, 1'b0},
    '{OP_MUL, 32'h0000_0003, 32'h0000_0003, 1'b1, 63'h5, 1'b0},
    '{OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 63'h0, 1'b0},
    // zero divisor
    '{OP_QUO, 32'h1234_5678, 32'h0000_0000, 1'b1, 63'h0, 1'b1},
    '{OP_REM, 32'hffff_ffff, 32'h0000_0000, 1'b1, 63'h0, 1'b1},
    '{OP_QUO, 32'h0000_0000, 32'h0000_0000, 1'b1, 63'h0, 1'b1},
    // divisor degree above the dividend degree
    '{OP_QUO, 32'h0000_0005, 32'h8000_0000, 1'b1, 63'h0, 1'b0},
    '{OP_REM, 32'h0000_0005, 32'h8000_0000, 1'b1, 63'h5, 1'b0},
    // equal degrees
    '{OP_QUO, 32'h8000_0001, 32'h8000_0000, 1'b1, 63'h1, 1'b0},
    '{OP_REM, 32'h8000_0001, 32'h8000_0000, 1'b1, 63'h1, 1'b0},
    '{OP_REM, 32'h8000_0000, 32'hffff_ffff, 1'b1, 63'h7fff_ffff, 1'b0},
    // unit divisor and zero dividend
    '{OP_QUO, 32'hffff_ffff, 32'h0000_0001, 1'b1, 63'hffff_ffff, 1'b0},
    '{OP_REM, 32'hffff_ffff, 32'h0000_0001, 1'b1, 63'h0, 1'b0},
    '{OP_QUO, 32'h0000_0000, 32'h0000_0007, 1'b1, 63'h0, 1'b0},
    // ordinary long divisions
    '{OP_QUO, 32'hffff_ffff, 32'h0000_0003, 1'b0, 63'h0, 1'b0},
    '{OP_REM, 32'hdead_beef, 32'h0000_011b, 1'b0, 63'h0, 1'b0}
  };

  gf2_polynomial_alu_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .out_valid          (out_valid),
    .out_result         (out_result),
    .out_divide_by_zero (out_divide_by_zero)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // answer of the unit for one word: xor, carry-less product or long division
  function automatic gf2_answer_t gf2_answer(opcode_t op, logic [IN_W-1:0] a_in,
                                             logic [IN_W-1:0] b_in);
    gf2_answer_t         ans;
    logic [IN_W-1:0]     a;
    logic [IN_W-1:0]     b;
    logic [IN_W-1:0]     rem;
    logic [IN_W-1:0]     quo;
    logic [RESULT_W-1:0] prod;
    int                  deg;
    a    = a_in & OPER_MASK;
    b    = b_in & OPER_MASK;
    ans  = '0;
    prod = '0;
    quo  = '0;
    rem  = a;
    deg  = 0;
    case (op)
      OP_ADD: begin
        ans.result = RESULT_W'(a ^ b);
      end
      OP_MUL: begin
        for (int i = 0; i < OPERAND_BITS; i++) begin
          if (b[i]) prod = prod ^ (RESULT_W'(a) << i);
        end
        ans.result = prod;
      end
      default: begin
        if (b == '0) begin
          ans.dbz = 1'b1;
        end else begin
          for (int i = 0; i < IN_W; i++) begin
            if (b[i]) deg = i;
          end
          for (int i = OPERAND_BITS - 1; i >= deg; i--) begin
            if (rem[i]) begin
              rem        = rem ^ (b << (i - deg));
              quo[i-deg] = 1'b1;
            end
          end
          ans.result = (op == OP_QUO) ? RESULT_W'(quo) : RESULT_W'(rem);
        end
      end
    endcase
    return ans;
  endfunction

  // random polynomial with a spread of degrees and the all-zero, all-one cases
  function automatic logic [IN_W-1:0] rand_poly();
    logic [IN_W-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      2:       v = IN_W'(1) << $urandom_range(IN_W - 1);
      3, 4:    v = $urandom;
      default: v = $urandom >> $urandom_range(IN_W - 1);
    endcase
    return v;
  endfunction

  // drive one word after a random gap, wait for it to be taken, log its answer
  task automatic send_word(opcode_t op, logic [IN_W-1:0] a, logic [IN_W-1:0] b,
                           logic typed, logic [RESULT_W-1:0] res, logic dbz,
                           int unsigned idle_pct);
    gf2_answer_t want;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed && OPERAND_BITS == IN_W) begin
      want.result = res;
      want.dbz    = dbz;
    end else begin
      want = gf2_answer(op, a, b);
    end
    expected_answers = {expected_answers, want};
    op_count[op]++;
    if (want.dbz) zero_divisor_count++;
  endtask

  // hold off until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    gf2_answer_t want;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: result word with none expected: result %h dbz %b",
                 $time, out_result, out_divide_by_zero);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        checked_count++;
        if (out_result !== want.result) begin
          $display("%0t: result mismatch: expected %h actual %h",
                   $time, want.result, out_result);
          error_count++;
        end
        if (out_divide_by_zero !== want.dbz) begin
          $display("%0t: divide_by_zero mismatch: expected %b actual %b",
                   $time, want.dbz, out_divide_by_zero);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("gf2_polynomial_alu_core_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned idle_pct;
    opcode_t     op;
    logic [IN_W-1:0] b;
    error_count        = 0;
    checked_count      = 0;
    zero_divisor_count = 0;
    op_count           = '{0, 0, 0, 0};
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_opcode    <= OP_ADD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner words back to back
    for (int i = 0; i < NUM_PROBES; i++) begin
      send_word(probe_rows[i].op, probe_rows[i].a, probe_rows[i].b,
                probe_rows[i].typed, probe_rows[i].result, probe_rows[i].dbz, 0);
    end
    drain_results();

    // random words: no gaps, heavy gaps, light gaps, no gaps again
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 63;
        2:       idle_pct = 31;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        op = opcode_t'($urandom_range(3));
        b  = ($urandom_range(19) == 0) ? '0 : rand_poly();
        send_word(op, rand_poly(), b, 1'b0, '0, 1'b0, idle_pct);
      end
      drain_results();
    end

    // let any stray result show up
    repeat (2 * LATENCY) @(posedge clk);
    if (expected_answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_answers.size());
      error_count++;
    end

    $display("covered %0d add, %0d multiply, %0d quotient, %0d remainder words",
             op_count[OP_ADD], op_count[OP_MUL], op_count[OP_QUO], op_count[OP_REM]);
    $display("%0d results checked, %0d zero divisors, %0d errors",
             checked_count, zero_divisor_count, error_count);
    if (error_count == 0) begin
      $display("gf2_polynomial_alu_core_tb OK");
    end else begin
      $display("gf2_polynomial_alu_core_tb NOT OK");
    end
    $finish;
  end

endmodule
